[hw/rtl/max_flow_edmonds_karp_defines.svh]
// Assertion macros for the max-flow block.
// Each macro checks one implication on the rising clock edge, outside reset.
`ifndef MAX_FLOW_EDMONDS_KARP_DEFINES_SVH
`define MAX_FLOW_EDMONDS_KARP_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define MFEK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("max flow assertion failed");

// Consequent holds in the cycle after the antecedent.
`define MFEK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("max flow assertion failed");

`endif

[hw/rtl/mfek_pkg.sv]
// ----------------------------------------------------------------------------
// mfek_pkg
// Shared constants, types and command codes of the max-flow block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mfek_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_BITS = $clog2(MAX_NODES);
  localparam int CNT_BITS  = NODE_BITS + 1;
  localparam int CAP_BITS  = 16;
  localparam int RES_BITS  = CAP_BITS + 1;
  localparam int FLOW_BITS = 22;
  localparam int RES_DEPTH = MAX_NODES * MAX_NODES;
  localparam int RES_ABITS = 2 * NODE_BITS;
  localparam int QUEUE_BITS = NODE_BITS + RES_BITS;
  localparam int CFG_BITS  = 7;
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;

  localparam logic [RES_BITS-1:0]  RES_MAX  = '1;
  localparam logic [FLOW_BITS-1:0] FLOW_MAX = '1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_BFS_INIT,
    S_DEQ,
    S_DEQ_LAT,
    S_RD,
    S_CHK,
    S_AUG,
    S_PAR,
    S_PAR_LAT,
    S_FWD_RD,
    S_FWD_WR,
    S_BWD_RD,
    S_BWD_WR,
    S_DONE
  } mfek_state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ADD,
    OP_RUN,
    OP_BFS_INIT,
    OP_DEQ,
    OP_DEQ_LAT,
    OP_RD,
    OP_CHK,
    OP_AUG,
    OP_PAR_RD,
    OP_PAR_LAT,
    OP_FWD_RD,
    OP_FWD_WR,
    OP_BWD_RD,
    OP_BWD_WR,
    OP_OUT
  } mfek_op_t;

  typedef struct packed {
    logic degenerate;
    logic q_empty;
    logic v_end;
    logic hit;
    logic hit_dst;
    logic av_src;
    logic clr_last;
    logic out_free;
  } mfek_status_t;

endpackage

`default_nettype wire

[hw/rtl/mfek_ram.sv]
// ----------------------------------------------------------------------------
// mfek_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfek_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/mfek_ctrl.sv]
// ----------------------------------------------------------------------------
// mfek_ctrl
// Controller: sequences clearing, edge loads, searches and augmentation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfek_ctrl
  import mfek_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic         cmd,
  output logic              in_ready,
  input  wire mfek_status_t status,
  output mfek_op_t          op
);

  mfek_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:    if (status.clr_last) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid && cmd) begin
          state_next = status.degenerate ? S_DONE : S_BFS_INIT;
        end
      end
      S_BFS_INIT: state_next = S_DEQ;
      S_DEQ:      state_next = status.q_empty ? S_DONE : S_DEQ_LAT;
      S_DEQ_LAT:  state_next = S_RD;
      S_RD:       state_next = status.v_end ? S_DEQ : S_CHK;
      S_CHK:      state_next = (status.hit && status.hit_dst) ? S_AUG : S_RD;
      S_AUG:      state_next = S_PAR;
      S_PAR:      state_next = status.av_src ? S_BFS_INIT : S_PAR_LAT;
      S_PAR_LAT:  state_next = S_FWD_RD;
      S_FWD_RD:   state_next = S_FWD_WR;
      S_FWD_WR:   state_next = S_BWD_RD;
      S_BWD_RD:   state_next = S_BWD_WR;
      S_BWD_WR:   state_next = S_PAR;
      S_DONE:     if (status.out_free) state_next = S_IDLE;
      default:    state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    op       = OP_NONE;
    case (state)
      S_CLEAR:    op = OP_CLEAR;
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = cmd ? OP_RUN : OP_ADD;
        end
      end
      S_BFS_INIT: op = OP_BFS_INIT;
      S_DEQ:      op = status.q_empty ? OP_NONE : OP_DEQ;
      S_DEQ_LAT:  op = OP_DEQ_LAT;
      S_RD:       op = status.v_end ? OP_NONE : OP_RD;
      S_CHK:      op = OP_CHK;
      S_AUG:      op = OP_AUG;
      S_PAR:      op = status.av_src ? OP_NONE : OP_PAR_RD;
      S_PAR_LAT:  op = OP_PAR_LAT;
      S_FWD_RD:   op = OP_FWD_RD;
      S_FWD_WR:   op = OP_FWD_WR;
      S_BWD_RD:   op = OP_BWD_RD;
      S_BWD_WR:   op = OP_BWD_WR;
      S_DONE:     op = status.out_free ? OP_OUT : OP_NONE;
      default:    op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/mfek_dp.sv]
// ----------------------------------------------------------------------------
// mfek_dp
// Datapath: residual matrix, search queue, parent store, flow total and
// the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfek_dp
  import mfek_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mfek_op_t             op,
  output mfek_status_t              status,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_BITS-1:0]  cfg_wdata,
  output logic      [CFG_BITS-1:0]  node_count,
  input  wire logic [NODE_BITS-1:0] from_node,
  input  wire logic [NODE_BITS-1:0] to_node,
  input  wire logic [CAP_BITS-1:0]  edge_capacity,
  input  wire logic [NODE_BITS-1:0] source_node,
  input  wire logic [NODE_BITS-1:0] sink_node,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [FLOW_BITS-1:0] max_flow
);

  logic [RES_ABITS-1:0]  clr;
  logic [NODE_BITS-1:0]  src, dst, u, au, av;
  logic [CNT_BITS-1:0]   v, head, tail;
  logic [RES_BITS-1:0]   neck, f;
  logic [FLOW_BITS-1:0]  flow;
  logic [MAX_NODES-1:0]  visited;

  logic                  res_we;
  logic [RES_ABITS-1:0]  res_waddr, res_raddr;
  logic [RES_BITS-1:0]   res_wdata, res_rdata;
  logic                  q_we;
  logic [NODE_BITS-1:0]  q_waddr;
  logic [QUEUE_BITS-1:0] q_wdata, q_rdata;
  logic                  par_we;
  logic [NODE_BITS-1:0]  par_rdata;

  logic [RES_BITS-1:0]   nn;
  logic [RES_BITS:0]     back_sum;
  logic [FLOW_BITS:0]    flow_sum;
  logic [CFG_BITS-1:0]   cfg_val;
  logic [NODE_BITS-1:0]  vi;

  assign vi       = v[NODE_BITS-1:0];
  assign nn       = (res_rdata < neck) ? res_rdata : neck;
  assign back_sum = {1'b0, res_rdata} + {1'b0, f};
  assign flow_sum = {1'b0, flow} + FLOW_BITS'(f);

  always_comb begin
    status.degenerate = (source_node == sink_node)
                     || ({1'b0, source_node} >= node_count)
                     || ({1'b0, sink_node} >= node_count);
    status.q_empty    = (head == tail);
    status.v_end      = (v == node_count);
    status.hit        = !visited[vi] && (res_rdata != '0);
    status.hit_dst    = (vi == dst);
    status.av_src     = (av == src);
    status.clr_last   = (clr == '1);
    status.out_free   = !out_valid || out_ready;
  end

  // Residual matrix port selection.
  always_comb begin
    res_we    = 1'b0;
    res_waddr = {au, av};
    res_wdata = res_rdata - f;
    res_raddr = {u, vi};
    case (op)
      OP_CLEAR: begin
        res_we    = 1'b1;
        res_waddr = clr;
        res_wdata = '0;
      end
      OP_ADD: begin
        res_we    = ({1'b0, from_node} < node_count) && ({1'b0, to_node} < node_count);
        res_waddr = {from_node, to_node};
        res_wdata = {1'b0, edge_capacity};
      end
      OP_FWD_RD: res_raddr = {au, av};
      OP_FWD_WR: res_we = 1'b1;
      OP_BWD_RD: res_raddr = {av, au};
      OP_BWD_WR: begin
        res_we    = 1'b1;
        res_waddr = {av, au};
        res_wdata = back_sum[RES_BITS] ? RES_MAX : back_sum[RES_BITS-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    q_we    = 1'b0;
    q_waddr = tail[NODE_BITS-1:0];
    q_wdata = {vi, nn};
    par_we  = 1'b0;
    case (op)
      OP_BFS_INIT: begin
        q_we    = 1'b1;
        q_waddr = '0;
        q_wdata = {src, RES_MAX};
      end
      OP_CHK: begin
        par_we = status.hit;
        q_we   = status.hit && !status.hit_dst && (tail < CNT_BITS'(MAX_NODES));
      end
      default: ;
    endcase
  end

  mfek_ram #(.WIDTH(RES_BITS), .DEPTH(RES_DEPTH)) u_res_ram (
    .clk   (clk),
    .we    (res_we),
    .waddr (res_waddr),
    .wdata (res_wdata),
    .raddr (res_raddr),
    .rdata (res_rdata)
  );

  mfek_ram #(.WIDTH(QUEUE_BITS), .DEPTH(MAX_NODES)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (head[NODE_BITS-1:0]),
    .rdata (q_rdata)
  );

  mfek_ram #(.WIDTH(NODE_BITS), .DEPTH(MAX_NODES)) u_parent_ram (
    .clk   (clk),
    .we    (par_we),
    .waddr (vi),
    .wdata (u),
    .raddr (av),
    .rdata (par_rdata)
  );

  // A written node count of zero is taken as one; large values clamp.
  always_comb begin
    cfg_val = cfg_wdata;
    if (cfg_wdata == '0) begin
      cfg_val = CFG_BITS'(1);
    end else if (cfg_wdata > CFG_BITS'(MAX_NODES)) begin
      cfg_val = CFG_BITS'(MAX_NODES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CFG_BITS'(MAX_NODES);
      clr        <= '0;
      out_valid  <= 1'b0;
      visited    <= '0;
      flow       <= '0;
      head       <= '0;
      tail       <= '0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_val;
      end
      if (op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (op)
        OP_CLEAR: clr <= clr + 1'b1;
        OP_RUN:   flow <= '0;
        OP_BFS_INIT: begin
          // Only the source is marked at the start of a search.
          visited <= {{(MAX_NODES-1){1'b0}}, 1'b1} << src;
          head    <= '0;
          tail    <= CNT_BITS'(1);
        end
        OP_DEQ: head <= head + 1'b1;
        OP_CHK: begin
          if (status.hit) begin
            visited[vi] <= 1'b1;
            if (!status.hit_dst && (tail < CNT_BITS'(MAX_NODES))) begin
              tail <= tail + 1'b1;
            end
          end
        end
        OP_AUG: flow <= flow_sum[FLOW_BITS] ? FLOW_MAX : flow_sum[FLOW_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (op)
      OP_RUN: begin
        src <= source_node;
        dst <= sink_node;
      end
      OP_DEQ_LAT: begin
        u    <= q_rdata[QUEUE_BITS-1:RES_BITS];
        neck <= q_rdata[RES_BITS-1:0];
        v    <= '0;
      end
      OP_CHK: begin
        if (status.hit && status.hit_dst) begin
          f <= nn;
        end
        v <= v + 1'b1;
      end
      OP_AUG:     av <= dst;
      OP_PAR_LAT: au <= par_rdata;
      OP_BWD_WR:  av <= au;
      OP_OUT:     max_flow <= flow;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/max_flow_edmonds_karp.sv]
// An edge load (cmd 0) leaves the block idle, so it is ready again the next cycle.
// A run (cmd 1) scans residual rows: it reads then checks each entry, dequeues each node,
// and per path edge reads the parent and updates both residuals, on one residual RAM port.
// The result is registered from the done state once the final search empties its queue;
// one run at a time. After reset each residual RAM entry is cleared before items are taken.
`timescale 1ns / 1ps
`default_nettype none
`include "max_flow_edmonds_karp_defines.svh"

// ----------------------------------------------------------------------------
// max_flow_edmonds_karp
// Edmonds-Karp maximum flow over a residual capacity matrix held in RAM.
// ----------------------------------------------------------------------------
module max_flow_edmonds_karp
  import mfek_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output logic      [DATA_BITS-1:0] prdata,
  output logic                      pready,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 cmd,
  input  wire logic [NODE_BITS-1:0] from_node,
  input  wire logic [NODE_BITS-1:0] to_node,
  input  wire logic [CAP_BITS-1:0]  edge_capacity,
  input  wire logic [NODE_BITS-1:0] source_node,
  input  wire logic [NODE_BITS-1:0] sink_node,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [FLOW_BITS-1:0] max_flow
);

  mfek_op_t            op;
  mfek_status_t        status;
  logic                cfg_we;
  logic [CFG_BITS-1:0] node_count;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[ADDR_BITS-1] == 1'b0);
  assign prdata = paddr[ADDR_BITS-1] ? '0 : DATA_BITS'(node_count);

  mfek_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .in_ready (in_ready),
    .status   (status),
    .op       (op)
  );

  mfek_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_wdata     (pwdata[CFG_BITS-1:0]),
    .node_count    (node_count),
    .from_node     (from_node),
    .to_node       (to_node),
    .edge_capacity (edge_capacity),
    .source_node   (source_node),
    .sink_node     (sink_node),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .max_flow      (max_flow)
  );

  // The datapath only takes input fields in the cycle a transaction is accepted.
  `MFEK_ASSERT_NOW(a_input_on_accept, (op == OP_ADD || op == OP_RUN), (in_valid && in_ready))
  // A run keeps the block busy for at least the following cycle.
  `MFEK_ASSERT_NEXT(a_run_busy, (in_valid && in_ready && cmd), (!in_ready))
  // A result is only presented after the controller asked for it.
  `MFEK_ASSERT_NOW(a_result_source, $rose(out_valid), $past(op == OP_OUT))

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives edge loads and max-flow runs into the Edmonds-Karp block, tracks the
// residual matrix in a local model and checks every reported flow value.
// ----------------------------------------------------------------------------
module testbench;
  import mfek_pkg::*;

  localparam logic [ADDR_BITS-1:0] NODE_COUNT_ADDR = '0;
  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_RUN = 1'b1;
  localparam logic [RES_BITS-1:0]  RES_TOP  = '1;
  localparam logic [FLOW_BITS-1:0] FLOW_TOP = '1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 cmd = 1'b0;
  logic [NODE_BITS-1:0] from_node = '0;
  logic [NODE_BITS-1:0] to_node = '0;
  logic [CAP_BITS-1:0]  edge_capacity = '0;
  logic [NODE_BITS-1:0] source_node = '0;
  logic [NODE_BITS-1:0] sink_node = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [FLOW_BITS-1:0] max_flow;

  // Local copy of the block state.
  logic [RES_BITS-1:0]  residual [MAX_NODES][MAX_NODES];
  logic                 seen [MAX_NODES];
  int                   came_from [MAX_NODES];
  int                   bfs_node [MAX_NODES];
  logic [RES_BITS-1:0]  bfs_neck [MAX_NODES];
  int                   nodes_in_use = MAX_NODES;

  logic [FLOW_BITS-1:0] expected_flow_q [$];
  int                   mismatches = 0;
  int                   burst_left = 0;
  bit                   sender_idles = 1'b1;
  int                   hold_left = 0;
  int                   rx_mode = 0;
  int                   rx_count = 0;

  always #1 clk = ~clk;

  max_flow_edmonds_karp dut (.*);

  task automatic report(input string what, input logic [FLOW_BITS-1:0] got,
                        input logic [FLOW_BITS-1:0] want);
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic logic [RES_BITS-1:0] find_augmenting_path(input int src, input int dst);
    int head;
    int tail;
    int u;
    logic [RES_BITS-1:0] neck;
    logic [RES_BITS-1:0] nn;
    head = 0;
    tail = 1;
    for (int i = 0; i < MAX_NODES; i++) seen[i] = 1'b0;
    seen[src] = 1'b1;
    came_from[src] = src;
    bfs_node[0] = src;
    bfs_neck[0] = RES_TOP;
    while (head < tail) begin
      u = bfs_node[head];
      neck = bfs_neck[head];
      head++;
      for (int v = 0; v < nodes_in_use; v++) begin
        if (!seen[v] && residual[u][v] != 0) begin
          nn = (residual[u][v] < neck) ? residual[u][v] : neck;
          seen[v] = 1'b1;
          came_from[v] = u;
          if (v == dst) return nn;
          if (tail < MAX_NODES) begin
            bfs_node[tail] = v;
            bfs_neck[tail] = nn;
            tail++;
          end
        end
      end
    end
    return '0;
  endfunction

  function automatic logic [FLOW_BITS-1:0] solve_max_flow(input int src, input int dst);
    logic [RES_BITS-1:0] f;
    logic [FLOW_BITS+1:0] total;
    logic [RES_BITS:0] back;
    int v;
    int u;
    total = '0;
    if (src == dst || src >= nodes_in_use || dst >= nodes_in_use) return '0;
    forever begin
      f = find_augmenting_path(src, dst);
      if (f == 0) break;
      total = total + f;
      if (total > FLOW_TOP) total = FLOW_TOP;
      v = dst;
      while (v != src) begin
        u = came_from[v];
        residual[u][v] = residual[u][v] - f;
        back = residual[v][u] + f;
        residual[v][u] = (back > RES_TOP) ? RES_TOP : back[RES_BITS-1:0];
        v = u;
      end
    end
    return total[FLOW_BITS-1:0];
  endfunction

  // Updates the local model for one accepted transaction.
  function automatic void predict_item(input logic c, input int a, input int b,
                                       input logic [CAP_BITS-1:0] capv,
                                       input int s, input int t);
    if (c == CMD_ADD) begin
      if (a < nodes_in_use && b < nodes_in_use) residual[a][b] = {1'b0, capv};
    end else begin
      expected_flow_q = {expected_flow_q, solve_max_flow(s, t)};
    end
  endfunction

  task automatic send_item(input logic c, input int a, input int b,
                           input logic [CAP_BITS-1:0] capv, input int s, input int t);
    in_valid <= 1'b1;
    cmd <= c;
    from_node <= a[NODE_BITS-1:0];
    to_node <= b[NODE_BITS-1:0];
    edge_capacity <= capv;
    source_node <= s[NODE_BITS-1:0];
    sink_node <= t[NODE_BITS-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(c, a, b, capv, s, t);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if (sender_idles) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
  endtask

  task automatic add_edge(input int a, input int b, input int capv);
    send_item(CMD_ADD, a, b, capv[CAP_BITS-1:0], $urandom_range(0, 63),
              $urandom_range(0, 63));
  endtask

  task automatic run_flow(input int s, input int t);
    send_item(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
              CAP_BITS'($urandom_range(0, 65535)), s, t);
  endtask

  // Waits for every expected result, then lets any trailing edge load settle.
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_flow_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_node_count(input int value);
    logic [6:0] v;
    // The register is only written once the block has nothing in flight.
    drain();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= NODE_COUNT_ADDR;
    pwdata <= {25'($urandom_range(0, 32'h1ff_ffff)), value[6:0]};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    v = value[6:0];
    if (v == 0) v = 7'd1;
    if (v > MAX_NODES) v = CFG_BITS'(MAX_NODES);
    nodes_in_use = v;
  endtask

  task automatic test_basic_paths;
    add_edge(0, 63, 65535);
    run_flow(0, 63);
    run_flow(0, 63);
    run_flow(63, 0);
    add_edge(5, 5, 1234);
    run_flow(5, 5);
    add_edge(1, 2, 0);
    run_flow(1, 2);
    add_edge(10, 11, 7);
    add_edge(11, 12, 3);
    add_edge(10, 12, 5);
    run_flow(10, 12);
    drain();
  endtask

  task automatic test_range_limits;
    write_node_count(0);
    add_edge(0, 0, 9);
    run_flow(0, 0);
    write_node_count(127);
    write_node_count(8);
    add_edge(9, 1, 100);
    add_edge(1, 9, 100);
    add_edge(1, 7, 40);
    run_flow(1, 9);
    run_flow(9, 1);
    run_flow(1, 7);
    drain();
  endtask

  task automatic test_reverse_saturation;
    write_node_count(4);
    add_edge(1, 2, 65535);
    add_edge(2, 1, 65535);
    run_flow(1, 2);
    add_edge(1, 2, 65535);
    run_flow(1, 2);
    run_flow(2, 1);
    drain();
  endtask

  task automatic test_total_saturation;
    write_node_count(40);
    for (int m = 1; m < 39; m++) begin
      add_edge(0, m, 65535);
      add_edge(m, 39, 65535);
    end
    run_flow(0, 39);
    run_flow(39, 0);
    run_flow(0, 39);
    drain();
  endtask

  task automatic test_output_backpressure;
    write_node_count(6);
    hold_left = 3000;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 0) run_flow($urandom_range(0, 5), $urandom_range(0, 5));
      else add_edge($urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(1, 500));
    end
    drain();
  endtask

  task automatic test_random_graphs;
    int cfg;
    int n;
    int pick;
    int capv;
    for (int phase = 0; phase < 14; phase++) begin
      pick = $urandom_range(0, 9);
      if (phase == 0) cfg = 64;
      else if (phase == 1) cfg = 1;
      else if (phase == 2) cfg = 2;
      else if (pick == 0) cfg = $urandom_range(65, 127);
      else if (pick == 1) cfg = 64;
      else cfg = $urandom_range(3, 10);
      write_node_count(cfg);
      sender_idles = (phase % 4 != 3);
      n = nodes_in_use;
      for (int i = 0; i < 100; i++) begin
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
          0: capv = 65535;
          1: capv = $urandom_range(0, 15);
          default: capv = $urandom_range(0, 65535);
        endcase
        if (pick < 6) begin
          add_edge($urandom_range(0, 63), $urandom_range(0, 63), capv);
        end else if (pick < 82) begin
          add_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1), capv);
        end else if (pick < 85) begin
          run_flow($urandom_range(0, 63), $urandom_range(0, 63));
        end else begin
          run_flow($urandom_range(0, n - 1), $urandom_range(0, n - 1));
        end
      end
      drain();
    end
    sender_idles = 1'b1;
  endtask

  // Result checker: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_flow_q.size() == 0) report("unexpected max_flow", max_flow, '0);
      else begin
        if (max_flow !== expected_flow_q[0]) report("max_flow", max_flow, expected_flow_q[0]);
        void'(expected_flow_q.pop_front());
      end
    end
  end

  // Receiver stalls follow their own pattern, with one long hold-off set by the backpressure test.
  always @(posedge clk) begin
    rx_count++;
    if (rx_count % 150 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_mode == 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, rx_mode) == 0);
    end
  end

  initial begin
    for (int i = 0; i < MAX_NODES; i++)
      for (int j = 0; j < MAX_NODES; j++) residual[i][j] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_basic_paths();
    test_range_limits();
    test_reverse_saturation();
    test_total_saturation();
    test_output_backpressure();
    test_random_graphs();
    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
